>>> rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, pipeline types and the CORDIC step angle table.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ANGLE_BITS   = 16;

   localparam int DATA_W      = 36;              // cordic datapath, holds gain growth
   localparam int ZW          = ANGLE_BITS + 2;  // angle accumulator
   localparam int OW          = 48;              // scaled angle before wrap
   localparam int IDX_W       = 5;
   localparam int SQRT_STEPS  = 31;              // root of values up to 2^60
   localparam int REM_W       = 61;
   localparam int STEP_SH     = 32 - ANGLE_BITS;

   localparam logic signed [DATA_W-1:0] HALF_Q30    = DATA_W'(64'sd536870912);
   localparam logic signed [DATA_W-1:0] LOCK_THRESH = DATA_W'(64'sd1073634450);

   localparam int LANE_HEAD  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_BANK  = 2;

   typedef struct packed {
      logic                     lock;
      logic signed [DATA_W-1:0] sp;
      logic signed [DATA_W-1:0] hy;
      logic signed [DATA_W-1:0] hx;
      logic signed [DATA_W-1:0] by;
      logic signed [DATA_W-1:0] bx;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0]      rem;
      logic [SQRT_STEPS-1:0] root;
      side_type              side;
   } sqrt_type;

   typedef struct packed {
      logic                     zero;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [ZW-1:0]     z;
   } lane_type;

   typedef struct packed {
      logic               lock;
      logic               sp_pos;
      lane_type [2:0]     lanes;
   } cordic_type;

   // atan(2^-i) in units of pi/2^31, rounded half up to ANGLE_BITS
   function automatic logic signed [ZW-1:0] step_angle(logic [IDX_W-1:0] i);
      logic [31:0] t;
      logic [32:0] r;
      case (i)
         5'd0:  t = 32'd536870912;
         5'd1:  t = 32'd316933406;
         5'd2:  t = 32'd167458907;
         5'd3:  t = 32'd85004756;
         5'd4:  t = 32'd42667331;
         5'd5:  t = 32'd21354465;
         5'd6:  t = 32'd10679838;
         5'd7:  t = 32'd5340245;
         5'd8:  t = 32'd2670163;
         5'd9:  t = 32'd1335087;
         5'd10: t = 32'd667544;
         5'd11: t = 32'd333772;
         5'd12: t = 32'd166886;
         5'd13: t = 32'd83443;
         5'd14: t = 32'd41722;
         5'd15: t = 32'd20861;
         5'd16: t = 32'd10430;
         5'd17: t = 32'd5215;
         5'd18: t = 32'd2608;
         5'd19: t = 32'd1304;
         5'd20: t = 32'd652;
         5'd21: t = 32'd326;
         5'd22: t = 32'd163;
         5'd23: t = 32'd81;
         5'd24: t = 32'd41;
         5'd25: t = 32'd20;
         5'd26: t = 32'd10;
         5'd27: t = 32'd5;
         5'd28: t = 32'd3;
         5'd29: t = 32'd1;
         5'd30: t = 32'd1;
         default: t = 32'd0;
      endcase
      if (STEP_SH > 0) begin
         r = ({1'b0, t} + (33'd1 << (STEP_SH > 0 ? STEP_SH - 1 : 0))) >> STEP_SH;
      end else begin
         r = {1'b0, t};
      end
      return $signed(ZW'(r));
   endfunction

endpackage

>>> rtl/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Unit quaternion (Q1.15) to heading, pitch and bank binary angles.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one quaternion per transaction (valid/ready). rsp_* returns
//   heading, pitch, bank and the gimbal lock flag, one transaction per input,
//   in order. csr_wr_en/csr_wr_data set the inverse direction bit; write it
//   only while no transaction is in flight.
//   The path runs through three product stages, 31 square root cells, a
//   pre-rotation stage, one cell per CORDIC step and the output register.
//   Throughput is one transaction per cycle while the receiver does not stall;
//   every cell holds its own item and the slowest part is one 31x31 multiply
//   or one 61-bit compare and subtract per stage.
//   Each cell stalls only when its successor is full, so a stalled receiver
//   fills the chain from the output back before req_ready drops, and bubbles
//   are squeezed out. Reset empties the chain and clears the direction bit.
// ----------------------------------------------------------------------------
module quaternion_to_euler import qte_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_heading_angle,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_bank_angle,
   output logic               rsp_gimbal_lock,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   function automatic lane_type prerotate(logic signed [DATA_W-1:0] y,
                                          logic signed [DATA_W-1:0] x);
      lane_type l;
      l.zero = (x == 0) && (y == 0);
      if (x < 0) begin
         l.x = -x;
         l.y = -y;
         l.z = ZW'(1) <<< (ANGLE_BITS - 1);
      end else begin
         l.x = x;
         l.y = y;
         l.z = '0;
      end
      return l;
   endfunction

   function automatic logic signed [OW-1:0] scale_angle(logic signed [ZW-1:0] z);
      logic signed [OW-1:0] t;
      t = OW'(z);
      if (ANGLE_BITS > 16) begin
         t = (t + (OW'(1) <<< (ANGLE_BITS > 16 ? ANGLE_BITS - 17 : 0)))
             >>> (ANGLE_BITS > 16 ? ANGLE_BITS - 16 : 0);
      end else begin
         t = t <<< (16 - ANGLE_BITS);
      end
      return t;
   endfunction

   logic inverse_ff;

   // product stage
   logic                     p0_valid_ff;
   logic                     p0_ready;
   logic signed [DATA_W-1:0] wx_ff, wy_ff, wz_ff, xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [16:0]       wn;

   // combine stage
   logic                     p1_valid_ff;
   logic                     p1_ready;
   side_type                 p1_side_ff;
   side_type                 p1_side_in;
   logic signed [30:0]       p1_spq_ff;
   logic signed [DATA_W-1:0] sp;

   // radicand stage
   logic                     p2_valid_ff;
   logic                     p2_ready;
   sqrt_type                 p2_data_ff;
   logic signed [61:0]       sp_sq;

   logic     sq_valid [SQRT_STEPS+1];
   logic     sq_ready [SQRT_STEPS+1];
   sqrt_type sq_data  [SQRT_STEPS+1];

   logic       pr_valid_ff;
   logic       pr_ready;
   cordic_type pr_data_ff;
   cordic_type pr_data_in;

   logic       co_valid [CORDIC_STEPS+1];
   logic       co_ready [CORDIC_STEPS+1];
   cordic_type co_data  [CORDIC_STEPS+1];

   logic                 rsp_valid_ff;
   logic signed [15:0]   heading_ff, pitch_ff, bank_ff;
   logic                 lock_ff;
   cordic_type           fin;
   logic signed [OW-1:0] head_s, pitch_s, bank_s;
   logic signed [15:0]   heading_in, pitch_in, bank_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_ff <= 1'b0;
      end else if (csr_wr_en) begin
         inverse_ff <= csr_wr_data;
      end
   end

   // ---------------- products ----------------
   assign wn        = inverse_ff ? -17'(req_quat_w) : 17'(req_quat_w);
   assign req_ready = p0_ready;
   assign p0_ready  = !p0_valid_ff || p1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (p0_ready) begin
         p0_valid_ff <= req_valid;
      end
      if (p0_ready && req_valid) begin
         wx_ff <= DATA_W'(wn * req_quat_x);
         wy_ff <= DATA_W'(wn * req_quat_y);
         wz_ff <= DATA_W'(wn * req_quat_z);
         xx_ff <= DATA_W'(req_quat_x * req_quat_x);
         yy_ff <= DATA_W'(req_quat_y * req_quat_y);
         zz_ff <= DATA_W'(req_quat_z * req_quat_z);
         xy_ff <= DATA_W'(req_quat_x * req_quat_y);
         xz_ff <= DATA_W'(req_quat_x * req_quat_z);
         yz_ff <= DATA_W'(req_quat_y * req_quat_z);
      end
   end

   // ---------------- combine, lock detect ----------------
   always_comb begin
      sp = (wx_ff - yz_ff) <<< 1;
      p1_side_in.sp   = sp;
      p1_side_in.lock = (sp >= LOCK_THRESH) || (sp <= -LOCK_THRESH);
      if (p1_side_in.lock) begin
         p1_side_in.hy = wy_ff - xz_ff;
         p1_side_in.hx = HALF_Q30 - yy_ff - zz_ff;
      end else begin
         p1_side_in.hy = xz_ff + wy_ff;
         p1_side_in.hx = HALF_Q30 - xx_ff - yy_ff;
      end
      p1_side_in.by = xy_ff + wz_ff;
      p1_side_in.bx = HALF_Q30 - xx_ff - zz_ff;
   end

   assign p1_ready = !p1_valid_ff || p2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (p1_ready) begin
         p1_valid_ff <= p0_valid_ff;
      end
      if (p1_ready && p0_valid_ff) begin
         p1_side_ff <= p1_side_in;
         // locked items skip the root, so keep the square in range
         p1_spq_ff  <= p1_side_in.lock ? '0 : 31'(sp);
      end
   end

   // ---------------- radicand 2^60 - sp^2 ----------------
   assign sp_sq    = 62'(p1_spq_ff * p1_spq_ff);
   assign p2_ready = !p2_valid_ff || sq_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (p2_ready) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (p2_ready && p1_valid_ff) begin
         p2_data_ff.rem  <= REM_W'((62'sd1 <<< 60) - sp_sq);
         p2_data_ff.root <= '0;
         p2_data_ff.side <= p1_side_ff;
      end
   end

   // ---------------- square root chain ----------------
   assign sq_valid[0] = p2_valid_ff;
   assign sq_data[0]  = p2_data_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      qte_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (IDX_W'(SQRT_STEPS - 1 - k)),
         .in_valid  (sq_valid[k]),
         .in_ready  (sq_ready[k]),
         .in_data   (sq_data[k]),
         .out_valid (sq_valid[k+1]),
         .out_ready (sq_ready[k+1]),
         .out_data  (sq_data[k+1])
      );
   end

   // ---------------- pre-rotation ----------------
   always_comb begin
      pr_data_in.lock   = sq_data[SQRT_STEPS].side.lock;
      pr_data_in.sp_pos = sq_data[SQRT_STEPS].side.sp > 0;
      pr_data_in.lanes[LANE_HEAD]  = prerotate(sq_data[SQRT_STEPS].side.hy,
                                               sq_data[SQRT_STEPS].side.hx);
      pr_data_in.lanes[LANE_PITCH] = prerotate(sq_data[SQRT_STEPS].side.sp,
                                               $signed(DATA_W'(sq_data[SQRT_STEPS].root)));
      pr_data_in.lanes[LANE_BANK]  = prerotate(sq_data[SQRT_STEPS].side.by,
                                               sq_data[SQRT_STEPS].side.bx);
   end

   assign sq_ready[SQRT_STEPS] = pr_ready;
   assign pr_ready             = !pr_valid_ff || co_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (pr_ready) begin
         pr_valid_ff <= sq_valid[SQRT_STEPS];
      end
      if (pr_ready && sq_valid[SQRT_STEPS]) begin
         pr_data_ff <= pr_data_in;
      end
   end

   // ---------------- cordic chain ----------------
   assign co_valid[0] = pr_valid_ff;
   assign co_data[0]  = pr_data_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      qte_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (IDX_W'(k)),
         .in_valid  (co_valid[k]),
         .in_ready  (co_ready[k]),
         .in_data   (co_data[k]),
         .out_valid (co_valid[k+1]),
         .out_ready (co_ready[k+1]),
         .out_data  (co_data[k+1])
      );
   end

   // ---------------- output register ----------------
   always_comb begin
      fin     = co_data[CORDIC_STEPS];
      head_s  = fin.lanes[LANE_HEAD].zero  ? '0 : scale_angle(fin.lanes[LANE_HEAD].z);
      pitch_s = fin.lanes[LANE_PITCH].zero ? '0 : scale_angle(fin.lanes[LANE_PITCH].z);
      bank_s  = fin.lanes[LANE_BANK].zero  ? '0 : scale_angle(fin.lanes[LANE_BANK].z);
      heading_in = head_s[15:0];
      if (fin.lock) begin
         pitch_in = fin.sp_pos ? 16'sd16384 : -16'sd16384;
         bank_in  = '0;
      end else begin
         if (pitch_s > OW'(16384)) begin
            pitch_in = 16'sd16384;
         end else if (pitch_s < -OW'(16384)) begin
            pitch_in = -16'sd16384;
         end else begin
            pitch_in = pitch_s[15:0];
         end
         bank_in = bank_s[15:0];
      end
   end

   assign co_ready[CORDIC_STEPS] = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (co_ready[CORDIC_STEPS]) begin
         rsp_valid_ff <= co_valid[CORDIC_STEPS];
      end
      if (co_ready[CORDIC_STEPS] && co_valid[CORDIC_STEPS]) begin
         heading_ff <= heading_in;
         pitch_ff   <= pitch_in;
         bank_ff    <= bank_in;
         lock_ff    <= fin.lock;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heading_angle = heading_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_bank_angle    = bank_ff;
   assign rsp_gimbal_lock   = lock_ff;

endmodule

>>> rtl/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One root digit of the restoring square root, one pipeline slot.
// ----------------------------------------------------------------------------
module qte_sqrt_cell import qte_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] step_idx,
   input  logic             in_valid,
   output logic             in_ready,
   input  sqrt_type         in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output sqrt_type         out_data
);

   logic             valid_ff;
   sqrt_type         data_ff;
   sqrt_type         data_in;
   logic [REM_W-1:0] trial;

   // root bits sit above step_idx, so the or is an add
   always_comb begin
      trial = (REM_W'(in_data.root) << (step_idx + 1)) | (REM_W'(1) << (2 * step_idx));
      data_in = in_data;
      if (in_data.rem >= trial) begin
         data_in.rem  = in_data.rem - trial;
         data_in.root = in_data.root | (SQRT_STEPS'(1) << step_idx);
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC iteration for the heading, pitch and bank lanes.
// ----------------------------------------------------------------------------
module qte_cordic_cell import qte_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] step_idx,
   input  logic             in_valid,
   output logic             in_ready,
   input  cordic_type       in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output cordic_type       out_data
);

   logic                 valid_ff;
   cordic_type           data_ff;
   cordic_type           data_in;
   logic signed [ZW-1:0] angle;

   always_comb begin
      angle   = step_angle(step_idx);
      data_in = in_data;
      for (int k = 0; k < 3; k++) begin
         if (in_data.lanes[k].y >= 0) begin
            data_in.lanes[k].x = in_data.lanes[k].x + (in_data.lanes[k].y >>> step_idx);
            data_in.lanes[k].y = in_data.lanes[k].y - (in_data.lanes[k].x >>> step_idx);
            data_in.lanes[k].z = in_data.lanes[k].z + angle;
         end else begin
            data_in.lanes[k].x = in_data.lanes[k].x - (in_data.lanes[k].y >>> step_idx);
            data_in.lanes[k].y = in_data.lanes[k].y + (in_data.lanes[k].x >>> step_idx);
            data_in.lanes[k].z = in_data.lanes[k].z - angle;
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/qte_checker.sv
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks on the result channel of quaternion_to_euler.
// ----------------------------------------------------------------------------
module qte_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_heading_angle,
   input logic signed [15:0] rsp_pitch_angle,
   input logic signed [15:0] rsp_bank_angle,
   input logic               rsp_gimbal_lock
);

   // a stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_heading_angle)
         && $stable(rsp_pitch_angle) && $stable(rsp_bank_angle)
         && $stable(rsp_gimbal_lock))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_lock_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gimbal_lock |-> rsp_bank_angle == 16'sd0
         && (rsp_pitch_angle == 16'sd16384 || rsp_pitch_angle == -16'sd16384))
      else $error("gimbal lock result with bank or pitch out of place");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_angle <= 16'sd16384 && rsp_pitch_angle >= -16'sd16384)
      else $error("pitch beyond a quarter turn");

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_heading_angle (rsp_heading_angle),
   .rsp_pitch_angle   (rsp_pitch_angle),
   .rsp_bank_angle    (rsp_bank_angle),
   .rsp_gimbal_lock   (rsp_gimbal_lock)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler testbench
// Drives quaternions through the valid/ready request channel and checks
// heading, pitch, bank and the lock flag against a bit-exact predictor,
// under both direction settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import qte_pkg::*;

   localparam int LATENCY     = 36 + CORDIC_STEPS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 600;

   typedef struct packed {
      logic signed [15:0] heading;
      logic signed [15:0] pitch;
      logic signed [15:0] bank;
      logic               lock;
   } euler_type;

   typedef struct {
      logic signed [15:0] w, x, y, z;
      logic               typed;
      euler_type          euler;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_quat_w = '0;
   logic signed [15:0] req_quat_x = '0;
   logic signed [15:0] req_quat_y = '0;
   logic signed [15:0] req_quat_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_heading_angle;
   logic signed [15:0] rsp_pitch_angle;
   logic signed [15:0] rsp_bank_angle;
   logic               rsp_gimbal_lock;
   logic               csr_wr_en = 1'b0;
   logic               csr_wr_data = 1'b0;

   euler_type euler_queue[$];
   logic      inverse_dir = 1'b0;
   int        error_count = 0;
   int        checked_count = 0;
   int        lock_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        hold_off = 0;

   quaternion_to_euler dut (
      .clock, .reset, .req_valid, .req_ready, .req_quat_w, .req_quat_x,
      .req_quat_y, .req_quat_z, .rsp_valid, .rsp_ready, .rsp_heading_angle,
      .rsp_pitch_angle, .rsp_bank_angle, .rsp_gimbal_lock, .csr_wr_en,
      .csr_wr_data
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint cordic_angle(longint y, longint x);
      longint acc;
      longint xs, ys, a;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         acc = longint'(1) << (ANGLE_BITS - 1);
      end
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         a = longint'(step_angle(5'(i)));
         if (y >= 0) begin
            x += ys; y -= xs; acc += a;
         end else begin
            x -= ys; y += xs; acc -= a;
         end
      end
      if (ANGLE_BITS > 16)
         return floor_shift(acc + (longint'(1) << (ANGLE_BITS - 17)), ANGLE_BITS - 16);
      if (ANGLE_BITS < 16)
         return acc <<< (16 - ANGLE_BITS);
      return acc;
   endfunction

   function automatic longint isqrt60(longint v);
      longint unsigned r, b, u;
      u = v;
      r = 0;
      b = 64'd1 << 62;
      while (b > u) b >>= 2;
      while (b != 0) begin
         if (u >= r + b) begin
            u -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic euler_type predict_euler(logic signed [15:0] qw, logic signed [15:0] qx,
                                               logic signed [15:0] qy, logic signed [15:0] qz);
      euler_type e;
      longint w, x, y, z, sp, c, p;
      w = qw; x = qx; y = qy; z = qz;
      if (inverse_dir) w = -w;
      sp = -2 * (y * z - w * x);
      e.lock = (sp >= 1073634450) || (sp <= -1073634450);
      if (e.lock) begin
         e.pitch = sp > 0 ? 16'sd16384 : -16'sd16384;
         e.heading = 16'(cordic_angle(-x * z + w * y, 536870912 - y * y - z * z));
         e.bank = '0;
      end else begin
         c = isqrt60((longint'(1) << 60) - sp * sp);
         p = cordic_angle(sp, c);
         if (p > 16384) p = 16384;
         if (p < -16384) p = -16384;
         e.pitch = 16'(p);
         e.heading = 16'(cordic_angle(x * z + w * y, 536870912 - x * x - y * y));
         e.bank = 16'(cordic_angle(x * y + w * z, 536870912 - x * x - z * z));
      end
      return e;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // result side: random stalls plus a long hold-off counted here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (euler_queue.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               euler_type e;
               e = euler_queue.pop_front();
               if (rsp_heading_angle !== e.heading)
                  report_mismatch("heading", int'(rsp_heading_angle), int'(e.heading));
               if (rsp_pitch_angle !== e.pitch)
                  report_mismatch("pitch", int'(rsp_pitch_angle), int'(e.pitch));
               if (rsp_bank_angle !== e.bank)
                  report_mismatch("bank", int'(rsp_bank_angle), int'(e.bank));
               if (rsp_gimbal_lock !== e.lock)
                  report_mismatch("lock", int'(rsp_gimbal_lock), int'(e.lock));
               checked_count++;
               if (e.lock) lock_count++;
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z,
                            logic typed, euler_type want);
      euler_type e;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      e = predict_euler(w, x, y, z);
      if (typed) begin
         if (e.heading !== want.heading)
            report_mismatch("typed heading", int'(e.heading), int'(want.heading));
         if (e.pitch !== want.pitch)
            report_mismatch("typed pitch", int'(e.pitch), int'(want.pitch));
         if (e.bank !== want.bank)
            report_mismatch("typed bank", int'(e.bank), int'(want.bank));
         if (e.lock !== want.lock)
            report_mismatch("typed lock", int'(e.lock), int'(want.lock));
      end
      euler_queue.push_back(e);
      req_valid <= 1'b1;
      req_quat_w <= w;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (euler_queue.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_dir(logic v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      inverse_dir = v;
   endtask

   task automatic random_quat(output logic signed [15:0] w, x, y, z);
      int kind;
      real a, b, c, d, n;
      kind = $urandom_range(9);
      if (kind < 7) begin
         // near-unit quaternion with random direction
         a = $itor($signed($urandom_range(65535) - 32768));
         b = $itor($signed($urandom_range(65535) - 32768));
         c = $itor($signed($urandom_range(65535) - 32768));
         d = $itor($signed($urandom_range(65535) - 32768));
         n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
         w = 16'($rtoi(a / n * 32767.0)); x = 16'($rtoi(b / n * 32767.0));
         y = 16'($rtoi(c / n * 32767.0)); z = 16'($rtoi(d / n * 32767.0));
      end else if (kind < 8) begin
         // close to gimbal lock: w ~ x, y ~ z small
         w = 16'($urandom_range(23170, 23100));
         x = ($urandom_range(1)) ? w : -w;
         y = 16'($signed($urandom_range(300) - 150));
         z = 16'($signed($urandom_range(300) - 150));
      end else begin
         w = 16'($urandom); x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      end
   endtask

   row_type rows[$];

   initial begin
      logic signed [15:0] w, x, y, z;
      euler_type none;
      none = '0;
      rows = '{
         '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
         '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
         '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
         '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
         '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0, '0},
         '{16'sd23170, 16'sd23170, 16'sd0, 16'sd0, 1'b0, '0},
         '{16'sd23170, -16'sd23170, 16'sd0, 16'sd0, 1'b0, '0},
         '{16'sd23170, 16'sd23169, 16'sd10, -16'sd10, 1'b0, '0},
         '{16'sd23170, 16'sd23000, 16'sd100, 16'sd50, 1'b0, '0},
         '{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 1'b0, '0},
         '{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0, '0},
         '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0, '0},
         '{16'sd23170, 16'sd0, 16'sd23170, 16'sd0, 1'b0, '0},
         '{16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 1'b0, '0},
         '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0, '0},
         '{16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b0, '0}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, both directions
      for (int pass = 0; pass < 2; pass++) begin
         foreach (rows[i])
            send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z,
                      rows[i].typed && !inverse_dir, rows[i].euler);
         drain_all();
         write_dir(~inverse_dir);
      end

      // long receiver hold-off while the sender keeps offering
      hold_off = 3 * LATENCY;
      for (int i = 0; i < 80; i++) begin
         random_quat(w, x, y, z);
         send_quat(w, x, y, z, 1'b0, none);
      end
      drain_all();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 70 : 0;
         recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 35 : 0;
         for (int i = 0; i < N_RANDOM / 3; i++) begin
            if (i == N_RANDOM / 6) begin
               drain_all();
               write_dir(1'($urandom_range(1)));
            end
            random_quat(w, x, y, z);
            send_quat(w, x, y, z, 1'b0, none);
         end
         drain_all();
         write_dir(phase[0]);
      end

      $display("checked %0d results, %0d in gimbal lock, both direction settings",
               checked_count, lock_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/qte_pkg.sv
rtl/qte_sqrt_cell.sv
rtl/qte_cordic_cell.sv
rtl/quaternion_to_euler.sv
rtl/qte_checker.sv
tb/tb.sv
